/* hdl/dmp_pkg.sv */
// Shared types and constants for the DNS message parser.
`timescale 1ns / 1ps
package dmp_pkg;

  localparam int MaxRes = 64;
  localparam int HdrLen = 12;

  // Result kinds
  localparam logic [4:0] K_LEN      = 5'd0;
  localparam logic [4:0] K_ID       = 5'd1;
  localparam logic [4:0] K_QR       = 5'd2;
  localparam logic [4:0] K_OPCODE   = 5'd3;
  localparam logic [4:0] K_AA       = 5'd4;
  localparam logic [4:0] K_TC       = 5'd5;
  localparam logic [4:0] K_RD       = 5'd6;
  localparam logic [4:0] K_RA       = 5'd7;
  localparam logic [4:0] K_RCODE    = 5'd8;
  localparam logic [4:0] K_QDCOUNT  = 5'd9;
  localparam logic [4:0] K_NAMECHAR = 5'd13;
  localparam logic [4:0] K_NAMEEND  = 5'd14;
  localparam logic [4:0] K_RDATA    = 5'd21;

  // Error codes
  localparam logic [1:0] E_NONE  = 2'd0;
  localparam logic [1:0] E_FWD   = 2'd1;
  localparam logic [1:0] E_EARLY = 2'd2;
  localparam logic [1:0] E_TRUNC = 2'd3;

  // Parse phases
  typedef enum logic [4:0] {
    PH_LEN_HI     = 5'd0,
    PH_LEN_LO     = 5'd1,
    PH_HEADER     = 5'd2,
    PH_NAME_START = 5'd3,
    PH_NAME_LEN   = 5'd4,
    PH_LABEL      = 5'd5,
    PH_PTR_LO     = 5'd6,
    PH_QTYPE      = 5'd15,
    PH_QCLASS     = 5'd16,
    PH_TYPE       = 5'd17,
    PH_CLASS      = 5'd18,
    PH_TTL        = 5'd19,
    PH_RDLEN      = 5'd20,
    PH_RDATA      = 5'd21,
    PH_SKIP       = 5'd22
  } phase_t;

  // One result item
  typedef struct packed {
    logic [4:0]  kind;
    logic [2:0]  section;
    logic [15:0] item_index;
    logic [31:0] value;
    logic [1:0]  error;
    logic        run_last;
    logic        message_end;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take_byte;  // apply the held input byte
    logic exp_start;  // load expansion pointer
    logic exp_step;   // consume one store byte during expansion
    logic emit_ack;   // pending result taken into output stage
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_exp;   // byte led to a pointer expansion
    logic exp_done;   // expansion finished, nameend queued
    logic emit_valid; // a result is pending
  } dp_sts_t;

endpackage

/* hdl/dmp_ram.sv */
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module dmp_ram #(
  parameter int Width = 8,
  parameter int Depth = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

/* hdl/dmp_datapath.sv */
// Parser datapath: field registers, result queue and name expansion walker.
`timescale 1ns / 1ps
module dmp_datapath #(
  parameter int StoreBytes = 512,
  parameter int NameChars  = 63
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       byte_in,
  input  dmp_pkg::dp_cmd_t cmd,
  output dmp_pkg::dp_sts_t sts,
  output dmp_pkg::result_t res
);
  import dmp_pkg::*;

  localparam int AW = $clog2(StoreBytes);
  localparam int QD = 8;
  localparam int QW = $clog2(QD);

  // Parse state
  phase_t      phase;
  logic [15:0] msg_len, seen, cur_item, rd_rem;
  logic [31:0] acc;
  logic [2:0]  fcnt;
  logic [15:0] counts [4];
  logic [2:0]  cur_sec;
  logic [7:0]  lab_rem, nchars;
  logic        trunc;

  // Result queue: up to six results per step, drained one per cycle while the output is free
  result_t     q [QD];
  logic [QW:0] q_n;
  logic [QW-1:0] q_rd;
  logic [6:0]  emitted; // results given so far for this byte

  // Expansion walker
  logic          exp_on;
  logic [15:0]   ep;
  logic [7:0]    e_len;
  logic          e_inlab;
  logic          exp_fin;
  logic          ram_we;
  logic [AW-1:0] ram_rd_addr;
  logic [7:0]    ram_q;

  dmp_ram #(.Width(8), .Depth(StoreBytes)) u_store (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(seen[AW-1:0]),
    .wr_data(byte_in),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_q)
  );

  assign ram_we = cmd.take_byte && phase != PH_LEN_HI && phase != PH_LEN_LO
                  && {16'd0, seen} < 32'(StoreBytes);
  assign ram_rd_addr = (cmd.exp_start ? ((acc[15:0] << 8) | 16'(byte_in)) & 16'h3FFF
                        : (cmd.exp_step ? ep + 16'd1 : ep)) >= 16'(StoreBytes)
                       ? '0 : AW'(cmd.exp_start ? (((acc[15:0] << 8) | 16'(byte_in)) & 16'h3FFF)
                                 : (cmd.exp_step ? ep + 16'd1 : ep));

  assign sts.emit_valid = q_n != '0;
  assign sts.exp_done   = exp_fin;
  assign res = q[q_rd];

  logic [15:0] avail;
  assign avail = {16'd0, seen} < 32'(StoreBytes) ? seen : 16'(StoreBytes);

  // Per-byte combinational decode into a local result list
  result_t     nr [8];
  logic [3:0]  nn;
  phase_t      ph_n;
  logic [31:0] acc_n;
  logic [2:0]  fcnt_n, sec_n;
  logic [15:0] item_n, rd_n, len_n, seen_n;
  logic [15:0] cnt_n [4];
  logic [7:0]  lab_n, nch_n;
  logic        tr_n, fin, need_exp;

  always_comb begin
    logic [15:0] idx, v16;
    logic [31:0] w;
    logic        inmsg, adv, sec_adv;
    logic [2:0]  s;
    idx = seen; v16 = '0; w = '0; inmsg = 1'b0; adv = 1'b0; sec_adv = 1'b0; s = '0;
    for (int i = 0; i < 8; i++) nr[i] = '0;
    nn = '0; ph_n = phase; acc_n = acc; fcnt_n = fcnt; sec_n = cur_sec; item_n = cur_item;
    rd_n = rd_rem; len_n = msg_len; seen_n = seen; lab_n = lab_rem; nch_n = nchars;
    tr_n = trunc; fin = 1'b0; need_exp = 1'b0;
    for (int i = 0; i < 4; i++) cnt_n[i] = counts[i];

    unique case (phase)
      PH_LEN_HI: begin
        len_n = {byte_in, 8'd0};
        ph_n = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_n = {msg_len[15:8], byte_in};
        seen_n = '0; sec_n = '0; item_n = '0; acc_n = '0; fcnt_n = '0;
        nr[0] = '{K_LEN, 3'd0, 16'd0, {16'd0, msg_len[15:8], byte_in}, E_NONE, 1'b0, 1'b0};
        nn = 4'd1; ph_n = PH_HEADER; inmsg = 1'b1;
      end
      default: begin
        seen_n = seen + 16'd1;
        inmsg = phase != PH_SKIP;
        unique case (phase)
          PH_HEADER: begin
            if (idx == 16'd0 || (idx >= 16'd4 && !idx[0])) begin
              acc_n = {24'd0, byte_in};
            end else if (idx == 16'd1) begin
              nr[0] = '{K_ID, 3'd0, 16'd0, {16'd0, acc[7:0], byte_in}, E_NONE, 1'b0, 1'b0};
              nn = 4'd1;
            end else if (idx == 16'd2) begin
              nr[0] = '{K_QR, 3'd0, 16'd0, 32'(byte_in[7]), E_NONE, 1'b0, 1'b0};
              nr[1] = '{K_OPCODE, 3'd0, 16'd0, 32'(byte_in[6:3]), E_NONE, 1'b0, 1'b0};
              nr[2] = '{K_AA, 3'd0, 16'd0, 32'(byte_in[2]), E_NONE, 1'b0, 1'b0};
              nr[3] = '{K_TC, 3'd0, 16'd0, 32'(byte_in[1]), E_NONE, 1'b0, 1'b0};
              nr[4] = '{K_RD, 3'd0, 16'd0, 32'(byte_in[0]), E_NONE, 1'b0, 1'b0};
              nn = 4'd5;
            end else if (idx == 16'd3) begin
              nr[0] = '{K_RA, 3'd0, 16'd0, 32'(byte_in[7]), E_NONE, 1'b0, 1'b0};
              nr[1] = '{K_RCODE, 3'd0, 16'd0, 32'(byte_in[3:0]), E_NONE, 1'b0, 1'b0};
              nn = 4'd2;
            end else begin
              v16 = {acc[7:0], byte_in};
              cnt_n[2'(idx[3:1] - 3'd2)] = v16;
              nr[0] = '{K_QDCOUNT + 5'(idx[3:1] - 3'd2), 3'd0, 16'd0, {16'd0, v16},
                        E_NONE, 1'b0, 1'b0};
              nn = 4'd1;
              if (idx == 16'(HdrLen - 1)) sec_adv = 1'b1;
            end
          end
          PH_NAME_START, PH_NAME_LEN: begin
            if (phase == PH_NAME_START && cur_sec >= 3'd2 && byte_in[7:6] == 2'b11) begin
              acc_n = {26'd0, byte_in[5:0]};
              ph_n = PH_PTR_LO;
            end else if (byte_in == 8'd0) begin
              nr[0] = '{K_NAMEEND, cur_sec, cur_item, {24'd0, nchars},
                        trunc ? E_TRUNC : E_NONE, 1'b0, 1'b0};
              nn = 4'd1; acc_n = '0; fcnt_n = '0;
              ph_n = cur_sec == 3'd1 ? PH_QTYPE : PH_TYPE;
            end else begin
              lab_n = byte_in; ph_n = PH_LABEL;
            end
          end
          PH_LABEL: begin
            if (32'(nchars) < 32'(NameChars)) begin
              nr[0] = '{K_NAMECHAR, cur_sec, cur_item, {24'd0, byte_in}, E_NONE, 1'b0, 1'b0};
              nn = 4'd1; nch_n = nchars + 8'd1;
            end else tr_n = 1'b1;
            lab_n = lab_rem - 8'd1;
            if (lab_rem == 8'd1) begin
              if (32'(nch_n) < 32'(NameChars)) begin
                nr[nn[2:0]] = '{K_NAMECHAR, cur_sec, cur_item, 32'd46, E_NONE, 1'b0, 1'b0};
                nn = nn + 4'd1; nch_n = nch_n + 8'd1;
              end else tr_n = 1'b1;
              ph_n = PH_NAME_LEN;
            end
          end
          PH_PTR_LO: begin
            need_exp = 1'b1;
            acc_n = acc; // pointer assembled by walker
            ph_n = PH_TYPE;
          end
          PH_RDATA: begin
            nr[0] = '{K_RDATA, cur_sec, cur_item, {24'd0, byte_in}, E_NONE, 1'b0, 1'b0};
            nn = 4'd1; rd_n = rd_rem - 16'd1;
            if (rd_rem == 16'd1) adv = 1'b1;
          end
          PH_SKIP: begin
            if (seen_n >= msg_len) ph_n = PH_LEN_HI;
          end
          PH_QTYPE, PH_QCLASS, PH_TYPE, PH_CLASS, PH_TTL, PH_RDLEN: begin
            w = {acc[23:0], byte_in};
            if ((fcnt + 3'd1) < (phase == PH_TTL ? 3'd4 : 3'd2)) begin
              acc_n = w; fcnt_n = fcnt + 3'd1;
            end else begin
              acc_n = '0; fcnt_n = '0;
              nr[0] = '{5'(phase), cur_sec, cur_item, w, E_NONE, 1'b0, 1'b0};
              nn = 4'd1;
              if (phase == PH_QCLASS) adv = 1'b1;
              else if (phase == PH_RDLEN) begin
                rd_n = w[15:0];
                if (w[15:0] == 16'd0) adv = 1'b1; else ph_n = PH_RDATA;
              end else ph_n = phase_t'(phase + 5'd1);
            end
          end
          default: ph_n = PH_LEN_HI;
        endcase
      end
    endcase

    // Next item, then next section
    if (adv) begin
      item_n = cur_item + 16'd1;
      if (cur_sec >= 3'd1 && cur_sec <= 3'd4 && item_n < cnt_n[2'(cur_sec - 3'd1)]) begin
        ph_n = PH_NAME_START;
      end else sec_adv = 1'b1;
    end
    if (sec_adv) begin
      s = cur_sec + 3'd1;
      for (int k = 0; k < 4; k++) begin
        if (s <= 3'd4 && cnt_n[2'(s - 3'd1)] == 16'd0) s = s + 3'd1;
      end
      sec_n = s; item_n = '0;
      if (s > 3'd4) begin
        fin = 1'b1;
        ph_n = seen_n >= msg_len ? PH_LEN_HI : PH_SKIP;
      end else ph_n = PH_NAME_START;
    end
    if (ph_n == PH_NAME_START && (adv || sec_adv)) begin
      nch_n = '0; tr_n = 1'b0; acc_n = '0; fcnt_n = '0;
    end
    // Results take the section and item in force when emitted
    for (int i = 0; i < 8; i++) begin
      if (nr[i].kind != K_LEN && nr[i].kind > K_QDCOUNT + 5'd3) begin
        nr[i].section = cur_sec; nr[i].item_index = cur_item;
      end
    end
    if (fin && nn != '0) nr[3'(nn - 4'd1)].message_end = 1'b1;
    // Early end closes the message unless an expansion still runs
    if (inmsg && !fin && !need_exp && seen_n >= len_n) begin
      nr[nn[2:0]] = '{K_LEN, sec_n, item_n, {16'd0, len_n}, E_EARLY, 1'b0, 1'b1};
      nn = nn + 4'd1; ph_n = PH_LEN_HI;
    end
    if (!need_exp && nn != '0) nr[3'(nn - 4'd1)].run_last = 1'b1;
  end

  assign sts.need_exp = need_exp;

  // Expansion walker decode over the registered store byte
  result_t    er;
  logic       e_emit, e_stop;
  logic [1:0] e_err;
  always_comb begin
    er = '{K_NAMECHAR, cur_sec, cur_item, {24'd0, ram_q}, E_NONE, 1'b0, 1'b0};
    e_emit = 1'b0; e_stop = 1'b0; e_err = E_NONE;
    if (ep >= avail) begin
      e_stop = 1'b1; e_err = E_FWD;
    end else if (!e_inlab) begin
      if (ram_q == 8'd0) e_stop = 1'b1;
    end else if (32'(nchars) >= 32'(NameChars)) begin
      e_stop = 1'b1; e_err = E_TRUNC;
    end else e_emit = 1'b1;
  end

  logic [1:0] dot_state; // 1: emit a dot at the next walker step
  logic       pending_dot;
  assign pending_dot = dot_state[0];

  // Registers
  always_ff @(posedge clk) begin
    logic [3:0] room;
    room = '0;
    if (rst) begin
      phase <= PH_LEN_HI; msg_len <= '0; seen <= '0; acc <= '0; fcnt <= '0;
      for (int i = 0; i < 4; i++) counts[i] <= '0;
      cur_sec <= '0; cur_item <= '0; lab_rem <= '0; rd_rem <= '0; nchars <= '0;
      trunc <= 1'b0; q_n <= '0; q_rd <= '0; exp_on <= 1'b0; ep <= '0; e_len <= '0;
      e_inlab <= 1'b0; exp_fin <= 1'b0; dot_state <= '0; emitted <= '0;
    end else begin
      exp_fin <= 1'b0;
      if (cmd.emit_ack) begin
        q_n <= q_n - 1'b1; q_rd <= q_rd + 1'b1;
      end
      if (cmd.take_byte) begin
        phase <= ph_n; msg_len <= len_n; seen <= seen_n; acc <= acc_n; fcnt <= fcnt_n;
        for (int i = 0; i < 4; i++) counts[i] <= cnt_n[i];
        cur_sec <= sec_n; cur_item <= item_n; lab_rem <= lab_n; rd_rem <= rd_n;
        nchars <= nch_n; trunc <= tr_n;
        for (int i = 0; i < 8; i++) begin
          if (4'(i) < nn) q[QW'(q_rd + QW'(i))] <= nr[i];
        end
        q_n <= (QW+1)'(nn);
        emitted <= 7'(nn);
      end
      if (cmd.exp_start) begin
        ep <= ((acc[15:0] << 8) | 16'(byte_in)) & 16'h3FFF;
        exp_on <= 1'b1; e_inlab <= 1'b0; dot_state <= '0;
      end else if (cmd.exp_step && exp_on) begin
        // one result slot per step, queue is empty here
        room = 4'd0;
        if (pending_dot) begin
          dot_state <= '0;
          if (32'(nchars) >= 32'(NameChars)) begin
            q[q_rd] <= '{K_NAMEEND, cur_sec, cur_item, {24'd0, nchars}, E_TRUNC, 1'b1, 1'b0};
            exp_on <= 1'b0; exp_fin <= 1'b1; room = 4'd1;
          end else begin
            q[q_rd] <= '{K_NAMECHAR, cur_sec, cur_item, 32'd46, E_NONE, 1'b0, 1'b0};
            nchars <= nchars + 8'd1; room = 4'd1;
          end
        end else if (e_stop) begin
          q[q_rd] <= '{K_NAMEEND, cur_sec, cur_item, {24'd0, nchars}, e_err, 1'b1, 1'b0};
          exp_on <= 1'b0; exp_fin <= 1'b1; room = 4'd1;
        end else begin
          ep <= ep + 16'd1;
          if (!e_inlab) begin
            e_len <= ram_q; e_inlab <= 1'b1;
          end else begin
            q[q_rd] <= er; nchars <= nchars + 8'd1; room = 4'd1;
            e_len <= e_len - 8'd1;
            if (e_len == 8'd1) begin
              e_inlab <= 1'b0; dot_state <= 2'd1;
            end
          end
        end
        if (room != '0) begin
          q_n <= (QW+1)'(1);
          emitted <= emitted + 7'd1;
        end
      end
      if (exp_fin) begin
        acc <= '0; fcnt <= '0;
        // early end after the nameend of an expanded name
        if (seen >= msg_len) begin
          phase <= PH_LEN_HI;
          q[q_rd] <= '{K_LEN, cur_sec, cur_item, {16'd0, msg_len}, E_EARLY, 1'b1, 1'b1};
          q_n <= (QW+1)'(1);
        end
      end
    end
  end

  // No result cap per byte is enforced; the top bit of the result count is only consumed here
  logic unused_room;
  assign unused_room = emitted[6] & 1'b0;

`ifndef SYNTHESIS
  // The queue never overflows its depth
  a_q_bound: assert property (@(posedge clk) disable iff (rst) q_n <= (QW+1)'(QD))
    else $error("result queue overflow");
  // A byte is only applied with the queue drained
  a_take_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.take_byte |-> q_n == '0) else $error("byte applied over pending results");
  // Expansion never starts while one is active
  a_exp_once: assert property (@(posedge clk) disable iff (rst)
    cmd.exp_start |-> !exp_on) else $error("nested expansion start");
`endif
endmodule

/* hdl/dmp_ctrl.sv */
// Parser controller: sequences byte intake, result drain and expansion.
`timescale 1ns / 1ps
module dmp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_fire,
  input  logic             out_free,
  input  dmp_pkg::dp_sts_t sts,
  output dmp_pkg::dp_cmd_t cmd,
  output logic             in_ready
);
  import dmp_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DRAIN, S_EXP_RD, S_EXP} state_t;
  state_t state;

  // Decode commands from state and status
  always_comb begin
    cmd = '0;
    cmd.take_byte = in_fire;
    cmd.exp_start = in_fire && sts.need_exp;
    cmd.emit_ack  = sts.emit_valid && out_free;
    cmd.exp_step  = state == S_EXP && !sts.emit_valid;
    in_ready      = state == S_IDLE && !sts.emit_valid;
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:   if (in_fire) state <= sts.need_exp ? S_EXP_RD : S_DRAIN;
        S_DRAIN:  if (!sts.emit_valid || (cmd.emit_ack && 1'b1)) state <= S_IDLE;
        S_EXP_RD: state <= S_EXP;
        S_EXP:    if (sts.exp_done) state <= S_DRAIN;
        default:  state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // Input is never taken while an expansion runs
  a_no_in_exp: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXP || state == S_EXP_RD) |-> !in_ready) else $error("input during expansion");
  // Expansion start always leads to the read state
  a_exp_seq: assert property (@(posedge clk) disable iff (rst)
    cmd.exp_start |=> state == S_EXP_RD) else $error("expansion sequencing");
  // Ready only with no pending result
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !sts.emit_valid) else $error("ready with results pending");
`endif
endmodule

/* hdl/dns_message_parser_unit.sv */
// Top level of the DNS message parser: stream ports, controller and datapath.
//
// channel  | dir | tdata fields (low bit up)                         | tuser/tlast
// s_axis   | in  | byte_in[7:0]                                      | -
// m_axis   | out | kind[4:0] section[7:5] item_index[23:8]            | tuser: error[1:0]
//          |     | value[55:24] message_end[56]                      | tlast: run_last
//
// A byte is accepted only with no results pending; the results it causes
// leave through a single output register fed from a small queue.
// A record name starting with a pointer walks the message store, one store
// byte per cycle through the registered RAM read while no result waits, with input held.
// Reset is synchronous; the store needs no clearing. Output stalls hold input.
`timescale 1ns / 1ps
module dns_message_parser_unit #(
  parameter int STORE_BYTES = 512,
  parameter int NAME_CHARS  = 63
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // byte_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // kind, section, item_index, value, message_end
  output logic [1:0]  m_axis_tuser,   // error
  output logic        m_axis_tlast    // run_last
);
  import dmp_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  result_t res;
  logic    in_fire, out_free;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  dmp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_free(out_free),
    .sts(sts), .cmd(cmd), .in_ready(s_axis_tready)
  );

  dmp_datapath #(.StoreBytes(STORE_BYTES), .NameChars(NAME_CHARS)) u_dp (
    .clk(clk), .rst(rst), .byte_in(s_axis_tdata), .cmd(cmd), .sts(sts), .res(res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= sts.emit_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (out_free && sts.emit_valid) begin
      m_axis_tdata <= {7'd0, res.message_end, res.value, res.item_index, res.section, res.kind};
      m_axis_tuser <= res.error;
      m_axis_tlast <= res.run_last;
    end
  end

`ifndef SYNTHESIS
  // A held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("payload moved");
`endif
endmodule
